// File: hdl/ptns_pkg.sv
package ptns_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned CoordW = 16;
  localparam int unsigned IdentW = 16;
  localparam int unsigned DepthW = 16;
  localparam int unsigned IndexW = 6;
  localparam logic [DepthW-1:0] HALF_DEPTH = 16'h8000;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_SELECT = 3'd2,
    KIND_NEAR2  = 3'd3,
    KIND_SETDEP = 3'd4,
    KIND_GETDEP = 3'd5,
    KIND_CLEAR  = 3'd6,
    KIND_NONE   = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHIFT,
    ST_SELECT,
    ST_REFRD,
    ST_NEAR,
    ST_NEARFIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request, reset scan counter
    logic scan_rd;     // issue read at scan counter and advance
    logic ref_rd;      // issue read at reference index
    logic find_eval;   // evaluate id match on returned data
    logic sel_eval;    // evaluate box rule on returned data
    logic ref_cap;     // capture reference point
    logic near_eval;   // evaluate distance on returned data
    logic shift_step;  // read entry above shift pointer
    logic shift_write; // move returned entry down by one
    logic finish;      // form result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  scan_end;   // scan counter has reached the entry count
    logic  found;      // id match seen
    logic  shift_end;  // shift pointer reached the end
    logic  ref_ok;     // reference index inside table
  } dp_stat_t;

endpackage

// File: hdl/point_table_nearest_search.sv
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_kind .. in_depth_in
// out     | output    | out_valid, out_ready, out_ok .. out_depth_out
// add, reset and unused kinds pass straight from ST_FIND to ST_DONE, with no table read.
// id lookups and searches visit one entry per cycle through a registered read
// port; a remove also shifts later entries down, each one read from the slot
// above it and then written one slot lower.
// reset is synchronous; the table memories are not cleared.
// a new request is taken the cycle after the previous result has been taken.
module point_table_nearest_search #(
  parameter int unsigned POINT_CAPACITY = ptns_pkg::DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [14:0]        in_search_range,
  input  logic [15:0]        in_point_id,
  input  logic [5:0]         in_point_index,
  input  logic [16:0]        in_depth_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [15:0]        out_id_out,
  output logic [5:0]         out_first_index,
  output logic [5:0]         out_second_index,
  output logic [15:0]        out_depth_out
);
  import ptns_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  ptns_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  // table and search datapath
  ptns_datapath #(.CAPACITY(POINT_CAPACITY)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_kind, .in_pos_x, .in_pos_y, .in_search_range, .in_point_id,
    .in_point_index, .in_depth_in,
    .res_ok(out_ok), .res_id_out(out_id_out), .res_first_index(out_first_index),
    .res_second_index(out_second_index), .res_depth_out(out_depth_out)
  );
endmodule

// File: hdl/ptns_datapath.sv
module ptns_datapath #(
  parameter int unsigned CAPACITY = ptns_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptns_pkg::dp_cmd_t           cmd,
  output ptns_pkg::dp_stat_t          stat,
  input  logic [2:0]                  in_kind,
  input  logic signed [15:0]          in_pos_x,
  input  logic signed [15:0]          in_pos_y,
  input  logic [14:0]                 in_search_range,
  input  logic [15:0]                 in_point_id,
  input  logic [5:0]                  in_point_index,
  input  logic [16:0]                 in_depth_in,
  output logic                        res_ok,
  output logic [15:0]                 res_id_out,
  output logic [5:0]                  res_first_index,
  output logic [5:0]                  res_second_index,
  output logic [15:0]                 res_depth_out
);
  import ptns_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // table memories
  logic [CoordW-1:0] mem_x [CAPACITY];
  logic [CoordW-1:0] mem_y [CAPACITY];
  logic [IdentW-1:0] mem_id [CAPACITY];
  logic [DepthW-1:0] mem_d [CAPACITY];

  // request capture
  kind_t             kind_r;
  logic signed [15:0] px_r, py_r;
  logic [15:0]       pid_r;
  logic [14:0]       rng_r;
  logic [5:0]        pidx_r;
  logic [16:0]       dep_r;

  logic [CW-1:0]     count_r;
  logic [IdentW-1:0] last_r;
  logic [CW-1:0]     scan_r;     // next address to read
  logic [AW-1:0]     rd_idx_r;   // index of returned data
  logic [CoordW-1:0] rx_r, ry_r, rid_r, rd_r;
  logic              found_r;
  logic [AW-1:0]     hit_r;
  logic [DepthW-1:0] hit_dep_r;  // depth of matched entry
  logic [AW-1:0]     sh_r;       // shift destination

  // search state
  logic              best_v_r;
  logic [AW-1:0]     best_r;
  logic [IdentW-1:0] best_id_r;
  logic [16:0]       lx_r, ly_r;
  logic signed [15:0] refx_r, refy_r;
  logic              b1v_r, b2v_r;
  logic [AW-1:0]     b1_r, b2_r;
  logic [32:0]       lo1_r, lo2_r;

  logic [CW-1:0]     rd_addr;
  logic              rd_en;

  assign rd_en   = cmd.scan_rd | cmd.shift_step | cmd.ref_rd;
  assign rd_addr = cmd.shift_step ? CW'(sh_r) + CW'(1) :
                   cmd.ref_rd     ? CW'(pidx_r)         : scan_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rx_r  <= mem_x[rd_addr[AW-1:0]];
      ry_r  <= mem_y[rd_addr[AW-1:0]];
      rid_r <= mem_id[rd_addr[AW-1:0]];
      rd_r  <= mem_d[rd_addr[AW-1:0]];
    end
    if (cmd.load && in_kind == KIND_ADD && count_r < CW'(CAPACITY)) begin
      mem_x[count_r[AW-1:0]]  <= in_pos_x;
      mem_y[count_r[AW-1:0]]  <= in_pos_y;
      mem_id[count_r[AW-1:0]] <= last_r + 16'd1;
      mem_d[count_r[AW-1:0]]  <= HALF_DEPTH;
    end
    if (cmd.shift_write) begin
      mem_x[sh_r]  <= rx_r;
      mem_y[sh_r]  <= ry_r;
      mem_id[sh_r] <= rid_r;
      mem_d[sh_r]  <= rd_r;
    end
    if (cmd.finish && kind_r == KIND_SETDEP && found_r && dep_r != 17'd0 && !dep_r[16])
      mem_d[hit_r] <= dep_r[15:0];
  end

  // distance terms on returned data
  logic signed [16:0] dxs, dys, ndx, ndy;
  logic [16:0]        adx, ady, ndxa, ndya;
  logic [33:0]        dsq_r;
  logic               dsq_v_r;
  logic [AW-1:0]      dsq_i_r;
  assign dxs  = 17'(signed'(rx_r)) - 17'(px_r);
  assign dys  = 17'(signed'(ry_r)) - 17'(py_r);
  assign adx  = dxs[16] ? 17'(-dxs) : 17'(dxs);
  assign ady  = dys[16] ? 17'(-dys) : 17'(dys);
  assign ndx  = 17'(signed'(rx_r)) - 17'(refx_r);
  assign ndy  = 17'(signed'(ry_r)) - 17'(refy_r);
  assign ndxa = ndx[16] ? 17'(-ndx) : 17'(ndx);
  assign ndya = ndy[16] ? 17'(-ndy) : 17'(ndy);

  logic sel_hit;
  assign sel_hit = adx < 17'(rng_r) && ady < 17'(rng_r) && (adx < lx_r || ady < ly_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      last_r  <= '0;
    end else begin
      if (cmd.load && in_kind == KIND_ADD && count_r < CW'(CAPACITY)) begin
        count_r <= count_r + CW'(1);
        last_r  <= last_r + 16'd1;
      end
      if (cmd.load && in_kind == KIND_CLEAR) begin
        count_r <= '0;
        last_r  <= '0;
      end
      if (cmd.finish && kind_r == KIND_REMOVE && found_r)
        count_r <= count_r - CW'(1);
    end
  end

  // scan and search registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= kind_t'(in_kind);
      px_r     <= in_pos_x;
      py_r     <= in_pos_y;
      rng_r    <= in_search_range;
      pid_r    <= in_point_id;
      pidx_r   <= in_point_index;
      dep_r    <= in_depth_in;
      scan_r   <= '0;
      found_r  <= 1'b0;
      best_v_r <= 1'b0;
      lx_r     <= {1'b0, in_search_range, 1'b0};
      ly_r     <= {1'b0, in_search_range, 1'b0};
      b1v_r    <= 1'b0;
      b2v_r    <= 1'b0;
      lo1_r    <= '1;
      lo2_r    <= '1;
    end
    if (cmd.scan_rd) begin
      rd_idx_r <= scan_r[AW-1:0];
      scan_r   <= scan_r + CW'(1);
    end
    if (cmd.ref_cap) begin
      refx_r <= rx_r;
      refy_r <= ry_r;
      scan_r <= '0;
    end
    if (cmd.find_eval && !found_r && rid_r == pid_r) begin
      found_r   <= 1'b1;
      hit_r     <= rd_idx_r;
      hit_dep_r <= rd_r;
      sh_r      <= rd_idx_r;
    end
    if (cmd.shift_write)
      sh_r <= sh_r + AW'(1);
    if (cmd.sel_eval && sel_hit) begin
      best_v_r  <= 1'b1;
      best_r    <= rd_idx_r;
      best_id_r <= rid_r;
      lx_r      <= adx;
      ly_r      <= ady;
    end
    // squared distance registered, then compared
    dsq_r   <= 34'(ndxa * ndxa) + 34'(ndya * ndya);
    dsq_v_r <= cmd.near_eval && 32'(rd_idx_r) != 32'(pidx_r);
    dsq_i_r <= rd_idx_r;
    if (dsq_v_r) begin
      if (dsq_r < 34'(lo1_r)) begin
        if (!b2v_r || lo2_r > lo1_r) begin
          b2v_r <= b1v_r;
          b2_r  <= b1_r;
          lo2_r <= lo1_r;
        end
        b1v_r <= 1'b1;
        b1_r  <= dsq_i_r;
        lo1_r <= dsq_r[32:0];
      end else if (dsq_r < 34'(lo2_r)) begin
        b2v_r <= 1'b1;
        b2_r  <= dsq_i_r;
        lo2_r <= dsq_r[32:0];
      end
    end
  end

  // result forming
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_ok           <= (in_kind == KIND_ADD && count_r < CW'(CAPACITY)) ||
                          in_kind == KIND_CLEAR;
      res_id_out       <= (in_kind == KIND_ADD && count_r < CW'(CAPACITY)) ?
                          last_r + 16'd1 : '0;
      res_first_index  <= '0;
      res_second_index <= '0;
      res_depth_out    <= '0;
    end else if (cmd.finish) begin
      case (kind_r)
        KIND_REMOVE: res_ok <= found_r;
        KIND_SETDEP: res_ok <= found_r && dep_r != 17'd0 && !dep_r[16];
        KIND_GETDEP: begin
          res_ok        <= found_r;
          res_depth_out <= found_r ? hit_dep_r : '0;
        end
        KIND_SELECT: begin
          res_ok          <= best_v_r;
          res_id_out      <= best_v_r ? best_id_r : '0;
          res_first_index <= best_v_r ? 6'(best_r) : '0;
        end
        KIND_NEAR2: begin
          res_ok           <= b1v_r && b2v_r;
          res_first_index  <= (b1v_r && b2v_r) ? 6'(b1_r) : '0;
          res_second_index <= (b1v_r && b2v_r) ? 6'(b2_r) : '0;
        end
        default: ;
      endcase
    end
  end

  assign stat.kind      = kind_r;
  assign stat.scan_end  = scan_r >= count_r;
  assign stat.found     = found_r;
  assign stat.shift_end = CW'(sh_r) + CW'(1) >= count_r;
  assign stat.ref_ok    = {{(16-CW){1'b0}}, count_r} > 16'(pidx_r);
endmodule

// File: hdl/ptns_ctrl.sv
module ptns_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ptns_pkg::dp_stat_t  stat,
  output ptns_pkg::dp_cmd_t   cmd
);
  import ptns_pkg::*;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;   // read data returning this cycle
  logic   ov_r, ov_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = 1'b0;
    ov_nxt    = ov_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !ov_r) state_nxt = ST_FIND;
      end
      ST_FIND: begin
        // dispatch on captured kind
        case (stat.kind)
          KIND_REMOVE, KIND_SETDEP, KIND_GETDEP: begin
            if (pend_r && stat.found) begin
              state_nxt = (stat.kind == KIND_REMOVE) ? ST_SHIFT : ST_DONE;
            end else if (stat.scan_end && !pend_r) begin
              state_nxt = ST_DONE;
            end else if (!stat.scan_end) begin
              pend_nxt = 1'b1;
            end
          end
          KIND_SELECT: state_nxt = ST_SELECT;
          KIND_NEAR2:  state_nxt = stat.ref_ok ? ST_REFRD : ST_DONE;
          default:     state_nxt = ST_DONE;
        endcase
      end
      ST_SELECT: begin
        if (!stat.scan_end) pend_nxt = 1'b1;
        else if (!pend_r) state_nxt = ST_DONE;
      end
      ST_REFRD: if (pend_r) state_nxt = ST_NEAR;
      else pend_nxt = 1'b1;
      ST_NEAR: begin
        if (!stat.scan_end) pend_nxt = 1'b1;
        else if (!pend_r) state_nxt = ST_NEARFIN;
      end
      ST_NEARFIN: state_nxt = ST_DONE;
      ST_SHIFT: begin
        if (pend_r && stat.shift_end) state_nxt = ST_DONE;
        else if (!pend_r && stat.shift_end) state_nxt = ST_DONE;
        else pend_nxt = !pend_r;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
        ov_nxt    = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready  = (state_r == ST_IDLE) && !ov_r;
    out_valid = ov_r;
    case (state_r)
      ST_IDLE: cmd.load = in_valid && !ov_r;
      ST_FIND: begin
        if (stat.kind == KIND_REMOVE || stat.kind == KIND_SETDEP ||
            stat.kind == KIND_GETDEP) begin
          cmd.find_eval = pend_r;
          cmd.scan_rd   = !stat.scan_end && !(pend_r && stat.found);
        end else if (stat.kind == KIND_NEAR2) begin
          cmd.scan_rd = 1'b0;
        end
      end
      ST_SELECT: begin
        cmd.sel_eval = pend_r;
        cmd.scan_rd  = !stat.scan_end;
      end
      ST_REFRD: begin
        cmd.ref_rd  = !pend_r;
        cmd.ref_cap = pend_r;
      end
      ST_NEAR: begin
        cmd.near_eval = pend_r;
        cmd.scan_rd   = !stat.scan_end;
      end
      ST_SHIFT: begin
        cmd.shift_step  = !pend_r && !stat.shift_end;
        cmd.shift_write = pend_r;
      end
      ST_DONE: cmd.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

// File: test/tb_point_table_nearest_search.sv
`timescale 1ns / 1ps

module tb_point_table_nearest_search;
  import ptns_pkg::*;

  localparam int unsigned CAP = 64;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam longint unsigned SQ_BOUND = 64'd2560000000000;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        search_range;
    logic [15:0]        point_id;
    logic [5:0]         point_index;
    logic [16:0]        depth_in;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] id_out;
    logic [5:0]  first_index;
    logic [5:0]  second_index;
    logic [15:0] depth_out;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_kind = '0;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic [14:0] in_search_range = '0;
  logic [15:0] in_point_id = '0;
  logic [5:0] in_point_index = '0;
  logic [16:0] in_depth_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ok;
  logic [15:0] out_id_out;
  logic [5:0] out_first_index;
  logic [5:0] out_second_index;
  logic [15:0] out_depth_out;

  // table model
  logic [15:0] tbl_x [CAP];
  logic [15:0] tbl_y [CAP];
  logic [15:0] tbl_id [CAP];
  logic [15:0] tbl_dep [CAP];
  int unsigned tbl_count;
  logic [15:0] issued_id;

  request_t pending_req[$];
  answer_t  expected_ans[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int n_sent = 0;
  int n_got = 0;
  bit hold_off = 1'b0;

  // acceptance flag from the last rising edge
  bit in_ready_seen = 1'b0;

  point_table_nearest_search u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void queue_req(request_t r);
    pending_req = {pending_req, r};
  endfunction

  function automatic int find_slot(logic [15:0] id);
    for (int i = 0; i < int'(tbl_count); i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int unsigned abs_gap(logic [15:0] a, logic [15:0] b);
    int sa, sb;
    sa = int'($signed(a));
    sb = int'($signed(b));
    return (sa > sb) ? sa - sb : sb - sa;
  endfunction

  // work out the answer to one request and update the table model
  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int k, best, b1, b2;
    int unsigned lx, ly, dx, dy;
    longint unsigned d, lo1, lo2;
    a = '0;
    case (kind_t'(r.kind))
      KIND_ADD: if (tbl_count < CAP) begin
        issued_id = issued_id + 16'd1;
        tbl_x[tbl_count] = r.pos_x;
        tbl_y[tbl_count] = r.pos_y;
        tbl_id[tbl_count] = issued_id;
        tbl_dep[tbl_count] = HALF_DEPTH;
        tbl_count++;
        a.ok = 1'b1;
        a.id_out = issued_id;
      end
      KIND_REMOVE: begin
        k = find_slot(r.point_id);
        if (k >= 0) begin
          for (int i = k; i + 1 < int'(tbl_count); i++) begin
            tbl_x[i] = tbl_x[i+1];
            tbl_y[i] = tbl_y[i+1];
            tbl_id[i] = tbl_id[i+1];
            tbl_dep[i] = tbl_dep[i+1];
          end
          tbl_count--;
          a.ok = 1'b1;
        end
      end
      KIND_SELECT: begin
        lx = {16'd0, r.search_range, 1'b0};
        ly = lx;
        best = -1;
        for (int i = 0; i < int'(tbl_count); i++) begin
          dx = abs_gap(tbl_x[i], r.pos_x);
          dy = abs_gap(tbl_y[i], r.pos_y);
          if (dx < r.search_range && dy < r.search_range && (dx < lx || dy < ly)) begin
            lx = dx;
            ly = dy;
            best = i;
          end
        end
        if (best >= 0) begin
          a.ok = 1'b1;
          a.id_out = tbl_id[best];
          a.first_index = best[5:0];
        end
      end
      KIND_NEAR2: if (r.point_index < tbl_count) begin
        b1 = -1;
        b2 = -1;
        lo1 = SQ_BOUND;
        lo2 = SQ_BOUND;
        for (int i = 0; i < int'(tbl_count); i++) begin
          if (i == r.point_index) continue;
          dx = abs_gap(tbl_x[i], tbl_x[r.point_index]);
          dy = abs_gap(tbl_y[i], tbl_y[r.point_index]);
          d = longint'(dx) * dx + longint'(dy) * dy;
          if (d < lo1) begin
            if (b2 == -1 || lo2 > lo1) begin
              b2 = b1;
              lo2 = lo1;
            end
            b1 = i;
            lo1 = d;
          end else if (d < lo2) begin
            b2 = i;
            lo2 = d;
          end
        end
        if (b1 >= 0 && b2 >= 0) begin
          a.ok = 1'b1;
          a.first_index = b1[5:0];
          a.second_index = b2[5:0];
        end
      end
      KIND_SETDEP: if (r.depth_in != 0 && r.depth_in < 17'd65536) begin
        k = find_slot(r.point_id);
        if (k >= 0) begin
          tbl_dep[k] = r.depth_in[15:0];
          a.ok = 1'b1;
        end
      end
      KIND_GETDEP: begin
        k = find_slot(r.point_id);
        if (k >= 0) begin
          a.ok = 1'b1;
          a.depth_out = tbl_dep[k];
        end
      end
      KIND_CLEAR: begin
        tbl_count = 0;
        issued_id = '0;
        a.ok = 1'b1;
      end
      default: ;
    endcase
    return a;
  endfunction

  // driver: present requests at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_req.size() > 0 && !hold_off &&
            $urandom_range(99) >= send_idle_pct) begin
          request_t r;
          r = pending_req.pop_front();
          in_valid <= 1'b1;
          in_kind <= r.kind;
          in_pos_x <= r.pos_x;
          in_pos_y <= r.pos_y;
          in_search_range <= r.search_range;
          in_point_id <= r.point_id;
          in_point_index <= r.point_index;
          in_depth_in <= r.depth_in;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    answer_t got, want;
    in_ready_seen <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        request_t r;
        r = {in_kind, in_pos_x, in_pos_y, in_search_range, in_point_id,
             in_point_index, in_depth_in};
        expected_ans = {expected_ans, predict_answer(r)};
        n_sent++;
      end
      if (out_valid && out_ready) begin
        got = {out_ok, out_id_out, out_first_index, out_second_index, out_depth_out};
        n_got++;
        if (expected_ans.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_ans.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            mismatches++;
          end
          if (got.id_out !== want.id_out) begin
            $error("id_out: expected %0d, got %0d", want.id_out, got.id_out);
            mismatches++;
          end
          if (got.first_index !== want.first_index) begin
            $error("first_index: expected %0d, got %0d", want.first_index,
                   got.first_index);
            mismatches++;
          end
          if (got.second_index !== want.second_index) begin
            $error("second_index: expected %0d, got %0d", want.second_index,
                   got.second_index);
            mismatches++;
          end
          if (got.depth_out !== want.depth_out) begin
            $error("depth_out: expected %0d, got %0d", want.depth_out, got.depth_out);
            mismatches++;
          end
        end
      end
      // watchdog
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout waiting for a handshake");
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic request_t rand_req(int unsigned live_ids);
    request_t r;
    r.kind = 3'($urandom_range(7));
    r.pos_x = 16'($urandom);
    r.pos_y = 16'($urandom);
    // mostly clustered coordinates so boxes and distances matter
    if ($urandom_range(3) != 0) begin
      r.pos_x = 16'(int'($urandom_range(255)) - 128);
      r.pos_y = 16'(int'($urandom_range(255)) - 128);
    end
    r.search_range = ($urandom_range(4) == 0) ? 15'($urandom) : 15'($urandom_range(200));
    r.point_id = ($urandom_range(4) == 0) ? 16'($urandom) :
                 16'($urandom_range(live_ids + 2));
    r.point_index = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(8));
    case ($urandom_range(5))
      0: r.depth_in = 17'd0;
      1: r.depth_in = 17'd65536 + 17'($urandom_range(65535));
      default: r.depth_in = 17'($urandom_range(65535));
    endcase
    return r;
  endfunction

  function automatic request_t mk(kind_t k, int x, int y, int rg, int id, int ix, int dp);
    request_t r;
    r.kind = k;
    r.pos_x = 16'(x);
    r.pos_y = 16'(y);
    r.search_range = 15'(rg);
    r.point_id = 16'(id);
    r.point_index = 6'(ix);
    r.depth_in = 17'(dp);
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_req.size() > 0 || in_valid || expected_ans.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int unsigned adds;
    tbl_count = 0;
    issued_id = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, each kind and tie cases
    queue_req(mk(KIND_SELECT, 0, 0, 100, 0, 0, 0));
    queue_req(mk(KIND_NEAR2, 0, 0, 0, 0, 0, 0));
    queue_req(mk(KIND_ADD, -32768, -32768, 0, 0, 0, 0));
    queue_req(mk(KIND_ADD, 32767, 32767, 0, 0, 0, 0));
    queue_req(mk(KIND_NEAR2, 0, 0, 0, 0, 0, 0));
    queue_req(mk(KIND_ADD, 10, 10, 0, 0, 0, 0));
    queue_req(mk(KIND_ADD, 10, 10, 0, 0, 0, 0));
    queue_req(mk(KIND_NEAR2, 0, 0, 0, 0, 2, 0));
    queue_req(mk(KIND_NEAR2, 0, 0, 0, 0, 63, 0));
    queue_req(mk(KIND_SELECT, 10, 10, 0, 0, 0, 0));
    queue_req(mk(KIND_SELECT, 12, 9, 32767, 0, 0, 0));
    queue_req(mk(KIND_SETDEP, 0, 0, 0, 3, 0, 0));
    queue_req(mk(KIND_SETDEP, 0, 0, 0, 3, 0, 65536));
    queue_req(mk(KIND_SETDEP, 0, 0, 0, 3, 0, 131071));
    queue_req(mk(KIND_SETDEP, 0, 0, 0, 3, 0, 65535));
    queue_req(mk(KIND_SETDEP, 0, 0, 0, 65535, 0, 1));
    queue_req(mk(KIND_GETDEP, 0, 0, 0, 3, 0, 0));
    queue_req(mk(KIND_GETDEP, 0, 0, 0, 1, 0, 0));
    queue_req(mk(KIND_GETDEP, 0, 0, 0, 65535, 0, 0));
    queue_req(mk(KIND_REMOVE, 0, 0, 0, 2, 0, 0));
    queue_req(mk(KIND_REMOVE, 0, 0, 0, 2, 0, 0));
    queue_req(mk(KIND_NONE, -1, -1, 32767, 65535, 63, 131071));
    queue_req(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // fill past capacity, then random work on a full table
    for (int i = 0; i < 66; i++)
      queue_req(mk(KIND_ADD, $urandom, $urandom, 0, 0, 0, 0));
    for (int i = 0; i < 30; i++) queue_req(rand_req(64));
    wait_drained();

    // pause until every result is in
    hold_off = 1'b1;
    repeat (20) @(posedge clk);
    hold_off = 1'b0;

    // random phases with differing idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      queue_req(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
      adds = 0;
      for (int i = 0; i < 270; i++) begin
        request_t r;
        r = rand_req(adds);
        // keep the table populated: bias towards adds
        if ($urandom_range(2) == 0) r.kind = KIND_ADD;
        if (r.kind == KIND_ADD) adds++;
        if ($urandom_range(199) == 0) begin
          r.kind = KIND_CLEAR;
          adds = 0;
        end
        queue_req(r);
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d requests and %0d results across four idle mixes,",
             n_sent, n_got);
    $display("including a full table, rejected depths and empty searches");
    if (mismatches == 0 && expected_ans.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
